// ===== design/rsc_pkg.sv =====
// Package for the roll-off roof shutter controller.
// Holds the operation, motion, request and status codes and the status evaluation function.
// No dependencies.
package rsc_pkg;

  typedef logic [2:0]  op_t;
  typedef logic [1:0]  mode_t;
  typedef logic [1:0]  req_t;
  typedef logic [2:0]  status_t;
  typedef logic [9:0]  relay_cnt_t;
  typedef logic [17:0] motion_cnt_t;

  localparam op_t OP_TICK  = 3'd0;
  localparam op_t OP_OPEN  = 3'd1;
  localparam op_t OP_CLOSE = 3'd2;
  localparam op_t OP_ABORT = 3'd3;
  localparam op_t OP_QUERY = 3'd4;

  localparam mode_t MODE_NONE    = 2'd0;
  localparam mode_t MODE_OPENING = 2'd1;
  localparam mode_t MODE_CLOSING = 2'd2;
  localparam mode_t MODE_ERROR   = 2'd3;

  localparam req_t REQ_NONE  = 2'd0;
  localparam req_t REQ_OPEN  = 2'd1;
  localparam req_t REQ_CLOSE = 2'd2;

  localparam status_t ST_OPEN    = 3'd0;
  localparam status_t ST_CLOSED  = 3'd1;
  localparam status_t ST_OPENING = 3'd2;
  localparam status_t ST_CLOSING = 3'd3;
  localparam status_t ST_ERROR   = 3'd4;

  localparam relay_cnt_t  RELAY_MAX  = '1;
  localparam motion_cnt_t MOTION_MAX = '1;

  localparam relay_cnt_t  RELAY_PULSE_RST    = 10'd250;
  localparam motion_cnt_t MOTION_TIMEOUT_RST = 18'd120000;

  localparam logic CFG_IDX_RELAY_PULSE    = 1'b0;
  localparam logic CFG_IDX_MOTION_TIMEOUT = 1'b1;

  // Shutter status seen from the switches, the motion mode and the last request.
  function automatic status_t eval_status(input logic closed_on, input logic open_on,
                                          input mode_t mode, input req_t req);
    status_t st;
    begin
      if (closed_on && open_on) begin
        st = ST_ERROR;
      end else if (closed_on) begin
        st = ST_CLOSED;
      end else if (open_on) begin
        st = (mode == MODE_CLOSING) ? ST_CLOSING : ST_OPEN;
      end else if (mode == MODE_OPENING) begin
        st = ST_OPENING;
      end else if (mode == MODE_CLOSING) begin
        st = ST_CLOSING;
      end else if (mode == MODE_ERROR) begin
        st = ST_ERROR;
      end else if (req == REQ_OPEN) begin
        st = ST_OPENING;
      end else if (req == REQ_CLOSE) begin
        st = ST_CLOSING;
      end else begin
        st = ST_ERROR;
      end
      return st;
    end
  endfunction

endpackage

// ===== design/rolloff_shutter_controller.sv =====
// Top level of the roll-off roof shutter controller.
// Depends on rsc_pkg for codes, types and the status evaluation function.
//
// The controller takes one request per clock cycle unless stalled: an op code (tick, open,
// close, abort or query) with the levels of the closed and open limit switches, and returns
// exactly one result per request holding the shutter status, a slewing flag and the relay
// drive level. A request is held in the input register and is then evaluated combinationally
// against the controller state as it moves into the output register, so the sustained rate
// is one request per cycle whenever the result side keeps taking. The pipeline only stalls
// while the output register holds a result that has not been taken. Configuration (relay
// pulse length and motion timeout, both in ticks) must only be written while no request is
// in flight; only tick requests advance the relay and motion counters, which saturate.
module rolloff_shutter_controller (
  input  logic        clk,
  input  logic        rst_n,
  // Input request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] op, [3] closed_switch_active,
                                  // [4] open_switch_active, [7:5] zero
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [2:0] shutter_status, [3] slewing, [4] relay_on,
                                  // [7:5] zero
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [17:0] cfg_wdata
);

  // Configuration registers.
  rsc_pkg::relay_cnt_t  relay_pulse_r;
  rsc_pkg::motion_cnt_t motion_timeout_r;

  // Controller state.
  rsc_pkg::mode_t       mode_r, mode_nxt;
  rsc_pkg::req_t        req_r, req_nxt;
  rsc_pkg::motion_cnt_t motion_elapsed_r, motion_elapsed_nxt;
  logic                 relay_active_r, relay_active_nxt;
  rsc_pkg::relay_cnt_t  relay_elapsed_r, relay_elapsed_nxt;

  // Input register.
  logic                 in_valid_r;
  rsc_pkg::op_t         op_r;
  logic                 closed_r;
  logic                 open_r;

  // Output register.
  logic                 out_valid_r;
  rsc_pkg::status_t     status_r, status_nxt;
  logic                 slewing_r, slewing_nxt;
  logic                 relay_on_r;

  logic                 advance;
  logic                 in_fire;
  logic                 eval_fire;

  rsc_pkg::status_t     st_pre;
  rsc_pkg::mode_t       mode_eval;
  rsc_pkg::req_t        req_eval;
  rsc_pkg::relay_cnt_t  relay_inc;
  rsc_pkg::motion_cnt_t motion_inc;

  // The output register can take a new result when it is empty or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;
  assign eval_fire = in_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_pulse_r    <= rsc_pkg::RELAY_PULSE_RST;
      motion_timeout_r <= rsc_pkg::MOTION_TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == rsc_pkg::CFG_IDX_RELAY_PULSE) begin
        relay_pulse_r <= cfg_wdata[9:0];
      end else begin
        motion_timeout_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_tdata[2:0];
      closed_r <= in_tdata[3];
      open_r   <= in_tdata[4];
    end
  end

  // Evaluation of one request: first the switch-driven status update, then the op itself.
  always_comb begin
    st_pre    = rsc_pkg::eval_status(closed_r, open_r, mode_r, req_r);
    mode_eval = mode_r;
    req_eval  = req_r;

    // Side effects of reading the switches.
    if (closed_r && open_r) begin
      mode_eval = rsc_pkg::MODE_ERROR;
      req_eval  = rsc_pkg::REQ_NONE;
    end else if (closed_r) begin
      mode_eval = rsc_pkg::MODE_NONE;
      if (req_r == rsc_pkg::REQ_CLOSE) begin
        req_eval = rsc_pkg::REQ_NONE;
      end
    end else if (open_r && (mode_r != rsc_pkg::MODE_CLOSING)) begin
      mode_eval = rsc_pkg::MODE_NONE;
      if (req_r == rsc_pkg::REQ_OPEN) begin
        req_eval = rsc_pkg::REQ_NONE;
      end
    end

    relay_inc  = (relay_elapsed_r < rsc_pkg::RELAY_MAX) ?
                 relay_elapsed_r + 10'd1 : relay_elapsed_r;
    motion_inc = (motion_elapsed_r < rsc_pkg::MOTION_MAX) ?
                 motion_elapsed_r + 18'd1 : motion_elapsed_r;

    mode_nxt           = mode_eval;
    req_nxt            = req_eval;
    motion_elapsed_nxt = motion_elapsed_r;
    relay_active_nxt   = relay_active_r;
    relay_elapsed_nxt  = relay_elapsed_r;

    case (op_r)
      rsc_pkg::OP_TICK: begin
        if (relay_active_r) begin
          relay_elapsed_nxt = relay_inc;
          if (relay_inc >= relay_pulse_r) begin
            relay_active_nxt = 1'b0;
          end
        end
        if (mode_eval inside {rsc_pkg::MODE_OPENING, rsc_pkg::MODE_CLOSING}) begin
          motion_elapsed_nxt = motion_inc;
          if (motion_inc > motion_timeout_r) begin
            mode_nxt = rsc_pkg::MODE_ERROR;
          end
        end
      end
      rsc_pkg::OP_OPEN: begin
        if (st_pre != rsc_pkg::ST_OPEN) begin
          req_nxt            = rsc_pkg::REQ_OPEN;
          mode_nxt           = rsc_pkg::MODE_OPENING;
          motion_elapsed_nxt = '0;
          relay_active_nxt   = 1'b1;
          relay_elapsed_nxt  = '0;
        end
      end
      rsc_pkg::OP_CLOSE: begin
        if (st_pre != rsc_pkg::ST_CLOSED) begin
          req_nxt            = rsc_pkg::REQ_CLOSE;
          mode_nxt           = rsc_pkg::MODE_CLOSING;
          motion_elapsed_nxt = '0;
          relay_active_nxt   = 1'b1;
          relay_elapsed_nxt  = '0;
        end
      end
      rsc_pkg::OP_ABORT: begin
        relay_active_nxt  = 1'b1;
        relay_elapsed_nxt = '0;
        mode_nxt          = rsc_pkg::MODE_ERROR;
      end
      default: begin
        // A query, or an unused code, only reports.
      end
    endcase

    // Reported status comes from the final state without further side effects.
    status_nxt  = rsc_pkg::eval_status(closed_r, open_r, mode_nxt, req_nxt);
    slewing_nxt = status_nxt inside {rsc_pkg::ST_OPENING, rsc_pkg::ST_CLOSING};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= rsc_pkg::MODE_NONE;
      req_r            <= rsc_pkg::REQ_NONE;
      motion_elapsed_r <= '0;
      relay_active_r   <= 1'b0;
      relay_elapsed_r  <= '0;
    end else if (eval_fire) begin
      mode_r           <= mode_nxt;
      req_r            <= req_nxt;
      motion_elapsed_r <= motion_elapsed_nxt;
      relay_active_r   <= relay_active_nxt;
      relay_elapsed_r  <= relay_elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_fire) begin
      status_r   <= status_nxt;
      slewing_r  <= slewing_nxt;
      relay_on_r <= relay_active_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, relay_on_r, slewing_r, status_r};

endmodule
